// File: hw/rtl/encoder_angle_unwrap_filter_top_defines.svh
// assertion macros for the encoder angle unwrap filter
`ifndef ENCODER_ANGLE_UNWRAP_FILTER_TOP_DEFINES_SVH
`define ENCODER_ANGLE_UNWRAP_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define EAUF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define EAUF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define EAUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EAUF_ASSERT_ALWAYS(lbl, cond, msg)
`define EAUF_ASSERT_IMPLY(lbl, ante, cons, msg)
`define EAUF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/eauf_pkg.sv
// shared types and constants of the encoder angle unwrap filter
package eauf_pkg;

  // field widths
  localparam int unsigned READING_W = 14;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned WEIGHT_W  = 7;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned WIDE_W    = 34;

  // turn geometry and blend scale
  localparam int HALF_TURN   = 18000;
  localparam int FULL_TURN   = 36000;
  localparam int WEIGHT_FULL = 100;
  localparam int JUMP_RESET  = 15;

  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT, exact for n below 2^23
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_100   = 10737419;

  // queue between front and back, and the result queue
  localparam int unsigned MID_DEPTH = 8;
  localparam int unsigned MID_CW    = 4;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_CW    = 4;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_FILTER_WEIGHT  = 1'b0;
  localparam logic REG_JUMP_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]   entry;
    logic [ANGLE_W-1:0] prev_angle;
    logic [DIFF_W-1:0]  diff;
    logic               bypass;
  } mid_word_t;

endpackage

// File: hw/rtl/encoder_angle_unwrap_filter_top.sv
// Encoder angle unwrap filter: calibration lookup, turn unwrap, jump-gated blend.
// A sample passes 3 front stages, the mid queue and 5 back stages; loads give no result.
// Throughput: one word per cycle unless full or result queue credit stalls it, set by
// the single-port table ram and the one-word-per-cycle back pipeline. Synchronous
// active-high reset clears control state, filter_weight to 0 and jump_threshold to 15;
// the table is not cleared.
`include "encoder_angle_unwrap_filter_top_defines.svh"

module encoder_angle_unwrap_filter_top #(
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic                                clk,
  input  logic                                rst,
  // input side
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type,
  input  logic [eauf_pkg::READING_W-1:0]      reading,
  input  logic [eauf_pkg::POS_W-1:0]          table_value,
  input  logic signed [eauf_pkg::ANGLE_W-1:0] prev_angle,
  input  logic [eauf_pkg::POS_W-1:0]          last_position,
  // result side
  output logic                                empty,
  input  logic                                pop,
  output logic signed [eauf_pkg::ANGLE_W-1:0] angle,
  output logic [eauf_pkg::POS_W-1:0]          position,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned OUT_W = eauf_pkg::ANGLE_W + eauf_pkg::POS_W;

  eauf_pkg::cfg_t                     cfg;
  logic [eauf_pkg::WEIGHT_W-1:0]      wr_weight;
  logic                               cfg_wr;

  logic                               mid_push;
  eauf_pkg::mid_word_t                mid_in;
  logic                               mid_pop;
  eauf_pkg::mid_word_t                mid_head;
  logic [eauf_pkg::MID_CW-1:0]        mid_count;
  logic                               mid_empty;

  logic                               out_push;
  logic signed [eauf_pkg::ANGLE_W-1:0] out_angle;
  logic [eauf_pkg::POS_W-1:0]         out_position;
  logic [OUT_W-1:0]                   out_head;
  logic [eauf_pkg::OUT_CW-1:0]        out_count;
  logic [2:0]                         back_inflight;
  logic                               out_take;
  logic [4:0]                         out_credit;
  logic                               last_take;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign wr_weight = (pwdata[eauf_pkg::WEIGHT_W-1:0] >
                      eauf_pkg::WEIGHT_W'(eauf_pkg::WEIGHT_FULL))
                     ? eauf_pkg::WEIGHT_W'(eauf_pkg::WEIGHT_FULL)
                     : pwdata[eauf_pkg::WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight    <= '0;
      cfg.threshold <= eauf_pkg::THRESH_W'(eauf_pkg::JUMP_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        eauf_pkg::REG_FILTER_WEIGHT:  cfg.weight    <= wr_weight;
        eauf_pkg::REG_JUMP_THRESHOLD: cfg.threshold <= pwdata[eauf_pkg::THRESH_W-1:0];
        default:                      cfg.weight    <= cfg.weight;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      eauf_pkg::REG_FILTER_WEIGHT:  prdata = 32'(cfg.weight);
      eauf_pkg::REG_JUMP_THRESHOLD: prdata = 32'(cfg.threshold);
      default:                      prdata = '0;
    endcase
  end

  // front end
  eauf_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .reading       (reading),
    .table_value   (table_value),
    .prev_angle    (prev_angle),
    .last_position (last_position),
    .cfg           (cfg),
    .mid_count     (mid_count),
    .mid_push      (mid_push),
    .mid_data      (mid_in)
  );

  // decoupling queue
  eauf_fifo #(
    .WIDTH ($bits(eauf_pkg::mid_word_t)),
    .DEPTH (eauf_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .pop       (mid_pop),
    .pop_data  (mid_head),
    .count     (mid_count)
  );

  assign mid_empty = (mid_count == '0);

  // back end
  eauf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .mid_empty    (mid_empty),
    .mid_data     (mid_head),
    .mid_pop      (mid_pop),
    .out_count    (out_count),
    .inflight     (back_inflight),
    .out_push     (out_push),
    .out_angle    (out_angle),
    .out_position (out_position)
  );

  // result queue
  assign out_take = pop && !empty;

  eauf_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (eauf_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data ({out_angle, out_position}),
    .pop       (out_take),
    .pop_data  (out_head),
    .count     (out_count)
  );

  assign empty    = (out_count == '0);
  assign angle    = $signed(out_head[OUT_W-1:eauf_pkg::POS_W]);
  assign position = out_head[eauf_pkg::POS_W-1:0];

  // check terms
  assign out_credit = 5'(out_count) + 5'(back_inflight);
  assign last_take  = out_take && (out_count == 4'd1) && !out_push;

  // checks
  `EAUF_ASSERT_ALWAYS(a_mid_bound, mid_count <= 4'(eauf_pkg::MID_DEPTH), "mid queue overflow")
  `EAUF_ASSERT_ALWAYS(a_out_credit, out_credit <= 5'(eauf_pkg::OUT_DEPTH), "credit exceeded")
  `EAUF_ASSERT_IMPLY(a_mid_pop_ok, mid_pop, !mid_empty, "back popped an empty queue")
  `EAUF_ASSERT_NEXT(a_last_drain, last_take, empty, "result queue did not drain")

endmodule

// File: hw/rtl/eauf_ram.sv
// generic single-port ram with registered read
module eauf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hw/rtl/eauf_fifo.sv
// small register fifo with occupancy count
module eauf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr_next;
  logic [AW-1:0]    rd_ptr_next;

  // pointer wrap
  assign wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  assign pop_data = mem[rd_ptr];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/eauf_front.sv
// front end: accept, table load or lookup, unwrap and jump classification
module eauf_front #(
  parameter int unsigned TABLE_DEPTH = 16384,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type,
  input  logic [eauf_pkg::READING_W-1:0]      reading,
  input  logic [eauf_pkg::POS_W-1:0]          table_value,
  input  logic signed [eauf_pkg::ANGLE_W-1:0] prev_angle,
  input  logic [eauf_pkg::POS_W-1:0]          last_position,
  input  eauf_pkg::cfg_t                      cfg,
  input  logic [eauf_pkg::MID_CW-1:0]         mid_count,
  output logic                                mid_push,
  output eauf_pkg::mid_word_t                 mid_data
);

  // reading mod depth by reciprocal: exact since reading < 2^14 <= 2^IDX_SHIFT / depth
  localparam int unsigned IDX_SHIFT = eauf_pkg::READING_W + AW;
  localparam longint unsigned IDX_RECIP =
    ((64'd1 << IDX_SHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH;
  localparam int unsigned PROD_W = 31;

  localparam logic signed [eauf_pkg::DIFF_W-1:0] HALF =
    eauf_pkg::DIFF_W'(eauf_pkg::HALF_TURN);
  localparam logic signed [eauf_pkg::DIFF_W-1:0] FULL =
    eauf_pkg::DIFF_W'(eauf_pkg::FULL_TURN);

  logic take;
  logic [1:0] inflight;

  logic [PROD_W-1:0] idx_prod;
  logic [PROD_W-1:0] idx_rem;
  logic [AW-1:0]     ram_addr;
  logic [eauf_pkg::POS_W-1:0] ram_rdata;

  // stage 0: accepted word
  logic                              s0_v;
  logic                              s0_load;
  logic [eauf_pkg::READING_W-1:0]    s0_reading;
  logic [eauf_pkg::READING_W-1:0]    s0_quot;
  logic [eauf_pkg::POS_W-1:0]        s0_value;
  logic [eauf_pkg::ANGLE_W-1:0]      s0_angle;
  logic [eauf_pkg::POS_W-1:0]        s0_pos;

  // stage 1: table entry arriving
  logic                              s1_v;
  logic [eauf_pkg::ANGLE_W-1:0]      s1_angle;
  logic [eauf_pkg::POS_W-1:0]        s1_pos;

  // stage 2: classified word
  logic                              s2_v;
  eauf_pkg::mid_word_t               s2_word;

  logic signed [eauf_pkg::DIFF_W-1:0] pos_delta;
  logic signed [eauf_pkg::DIFF_W-1:0] turn_diff;
  logic [eauf_pkg::DIFF_W-1:0]        diff_mag;

  // credit against the mid queue covers every word in flight here
  assign inflight = {1'b0, s0_v} + {1'b0, s1_v} + {1'b0, s2_v};
  assign full = (5'(mid_count) + 5'(inflight)) >= 5'(eauf_pkg::MID_DEPTH);
  assign take = push && !full;

  assign idx_prod = PROD_W'(reading) * PROD_W'(IDX_RECIP);
  assign idx_rem  = PROD_W'(s0_reading) - PROD_W'(s0_quot) * PROD_W'(TABLE_DEPTH);
  assign ram_addr = idx_rem[AW-1:0];

  eauf_ram #(
    .WIDTH (eauf_pkg::POS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (s0_v),
    .we    (s0_load),
    .addr  (ram_addr),
    .wdata (s0_value),
    .rdata (ram_rdata)
  );

  // unwrap across the turn boundary, then compare magnitude to threshold
  always_comb begin
    pos_delta = $signed({2'b00, ram_rdata}) - $signed({2'b00, s1_pos});
    if (pos_delta < -HALF) begin
      turn_diff = pos_delta + FULL;
    end else if (pos_delta > HALF) begin
      turn_diff = pos_delta - FULL;
    end else begin
      turn_diff = pos_delta;
    end
    diff_mag = turn_diff[eauf_pkg::DIFF_W-1] ? eauf_pkg::DIFF_W'(-turn_diff)
                                             : eauf_pkg::DIFF_W'(turn_diff);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s0_v <= take;
      s1_v <= s0_v && !s0_load;
      s2_v <= s1_v;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    s0_load    <= (req_type == eauf_pkg::REQ_LOAD);
    s0_reading <= reading;
    s0_quot    <= eauf_pkg::READING_W'(idx_prod >> IDX_SHIFT);
    s0_value   <= table_value;
    s0_angle   <= prev_angle;
    s0_pos     <= last_position;
    s1_angle   <= s0_angle;
    s1_pos     <= s0_pos;
    s2_word.entry      <= ram_rdata;
    s2_word.prev_angle <= s1_angle;
    s2_word.diff       <= turn_diff;
    s2_word.bypass     <= diff_mag > {2'b00, cfg.threshold};
  end

  assign mid_push = s2_v;
  assign mid_data = s2_word;

endmodule

// File: hw/rtl/eauf_back.sv
// back end: weighted blend, truncating divide by 100, saturation
module eauf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  eauf_pkg::cfg_t                      cfg,
  input  logic                                mid_empty,
  input  eauf_pkg::mid_word_t                 mid_data,
  output logic                                mid_pop,
  input  logic [eauf_pkg::OUT_CW-1:0]         out_count,
  output logic [2:0]                          inflight,
  output logic                                out_push,
  output logic signed [eauf_pkg::ANGLE_W-1:0] out_angle,
  output logic [eauf_pkg::POS_W-1:0]          out_position
);

  localparam int unsigned PROD_W = 26;
  localparam int unsigned MAG_W  = 24;
  localparam int unsigned QM_W   = 18;
  localparam int unsigned Q_W    = 19;
  localparam int unsigned W      = eauf_pkg::WIDE_W;
  localparam int unsigned AWD    = eauf_pkg::ANGLE_W;

  logic [eauf_pkg::WEIGHT_W-1:0] keep_w;
  logic signed [PROD_W-1:0]      blend_prod;
  logic [MAG_W-1:0]              mag_n;
  logic [2*MAG_W-1:0]            recip_prod;
  logic [QM_W+6:0]               qm_x100;
  logic [MAG_W-1:0]              rem;
  logic                          rem_nz;
  logic signed [Q_W-1:0]         qm_s;
  logic signed [Q_W-1:0]         quot;
  logic                          round_up;
  logic signed [W-1:0]           pick;

  // pipeline valids
  logic b1_v, b2_v, b3_v, b4_v, b5_v;

  // carried payload
  logic [eauf_pkg::POS_W-1:0] b1_entry, b2_entry, b3_entry, b4_entry;
  logic signed [AWD-1:0]      b1_angle, b2_angle, b3_angle;
  logic signed [W-1:0]        b1_fresh, b2_fresh, b3_fresh, b4_fresh;
  logic                       b1_bypass, b2_bypass, b3_bypass, b4_bypass;
  logic signed [PROD_W-1:0]   b1_prod;
  logic [MAG_W-1:0]           b2_n;
  logic                       b2_neg;
  logic [QM_W-1:0]            b2_qm;
  logic signed [Q_W-1:0]      b3_q;
  logic                       b3_rnz;
  logic signed [W-1:0]        b4_sum;
  logic                       b4_rnz;
  logic signed [AWD-1:0]      b5_angle;
  logic [eauf_pkg::POS_W-1:0] b5_pos;

  // pop only when the result queue has room for everything in flight
  assign inflight = 3'(b1_v) + 3'(b2_v) + 3'(b3_v) + 3'(b4_v) + 3'(b5_v);
  assign mid_pop = !mid_empty &&
                   ((5'(out_count) + 5'(inflight)) < 5'(eauf_pkg::OUT_DEPTH));

  // stage 1: e = (100 - a) * d, since the blend equals (100*L + e) / 100
  assign keep_w     = eauf_pkg::WEIGHT_W'(eauf_pkg::WEIGHT_FULL) - cfg.weight;
  assign blend_prod = $signed({1'b0, keep_w}) * $signed(mid_data.diff);

  // stage 2: floor(|e| / 100) by reciprocal
  assign mag_n      = b1_prod[PROD_W-1] ? MAG_W'(-b1_prod) : MAG_W'(b1_prod);
  assign recip_prod = {{MAG_W{1'b0}}, mag_n} * (2*MAG_W)'(eauf_pkg::RECIP_100);

  // stage 3: remainder and floor quotient of signed e
  always_comb begin
    qm_x100 = (QM_W + 7)'(b2_qm) * (QM_W + 7)'(eauf_pkg::WEIGHT_FULL);
    rem     = b2_n - qm_x100[MAG_W-1:0];
    rem_nz  = (rem != '0);
    qm_s    = $signed({1'b0, b2_qm});
    if (b2_neg) begin
      quot = rem_nz ? (-qm_s - Q_W'(1)) : -qm_s;
    end else begin
      quot = qm_s;
    end
  end

  // stage 5: floor to truncation, select path, saturate
  always_comb begin
    round_up = b4_sum[W-1] && b4_rnz;
    pick = b4_bypass ? b4_fresh : (b4_sum + W'(round_up));
  end

  // valid shift
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b5_v <= 1'b0;
    end else begin
      b1_v <= mid_pop;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b5_v <= b4_v;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    b1_entry  <= mid_data.entry;
    b1_angle  <= $signed(mid_data.prev_angle);
    b1_fresh  <= $signed({{2{mid_data.prev_angle[AWD-1]}}, mid_data.prev_angle}) +
                 $signed({{(W - eauf_pkg::DIFF_W){mid_data.diff[eauf_pkg::DIFF_W-1]}},
                          mid_data.diff});
    b1_bypass <= mid_data.bypass;
    b1_prod   <= blend_prod;

    b2_entry  <= b1_entry;
    b2_angle  <= b1_angle;
    b2_fresh  <= b1_fresh;
    b2_bypass <= b1_bypass;
    b2_n      <= mag_n;
    b2_neg    <= b1_prod[PROD_W-1];
    b2_qm     <= recip_prod[eauf_pkg::RECIP_SHIFT +: QM_W];

    b3_entry  <= b2_entry;
    b3_angle  <= b2_angle;
    b3_fresh  <= b2_fresh;
    b3_bypass <= b2_bypass;
    b3_q      <= quot;
    b3_rnz    <= rem_nz;

    b4_entry  <= b3_entry;
    b4_fresh  <= b3_fresh;
    b4_bypass <= b3_bypass;
    b4_sum    <= $signed({{(W - Q_W){b3_q[Q_W-1]}}, b3_q}) +
                 $signed({{(W - AWD){b3_angle[AWD-1]}}, b3_angle});
    b4_rnz    <= b3_rnz;

    b5_pos    <= b4_entry;
    if ((pick[W-1:AWD-1] == '0) || (pick[W-1:AWD-1] == '1)) begin
      b5_angle <= pick[AWD-1:0];
    end else if (pick[W-1]) begin
      b5_angle <= {1'b1, {(AWD - 1){1'b0}}};
    end else begin
      b5_angle <= {1'b0, {(AWD - 1){1'b1}}};
    end
  end

  assign out_push     = b5_v;
  assign out_angle    = b5_angle;
  assign out_position = b5_pos;

endmodule
